// ----- sv/alis_pkg.sv -----
// Package for the array list with insert-shift: sizes, codes and the
// broadcast bus that runs along the row of storage cells.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package alis_pkg;

  // List capacity and derived widths
  localparam int unsigned CAPACITY = 128;
  localparam int unsigned IdxW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW     = $clog2(CAPACITY + 1);
  localparam int unsigned PosW     = 7;
  localparam int unsigned CmpW     = (CntW > PosW) ? CntW : PosW;
  localparam int unsigned DataW    = 32;
  localparam int unsigned CountOutW = 8;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_INSERT = 2'd2,
    OP_READ   = 2'd3
  } alis_op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } alis_status_e;

  // Write command seen by every cell in the same cycle
  typedef struct packed {
    logic              wr;
    logic [IdxW-1:0]   pos;
    logic [CntW-1:0]   len;
    logic [DataW-1:0]  value;
  } alis_bcast_t;

endpackage : alis_pkg

`default_nettype wire

// ----- sv/alis_cell.sv -----
// One storage cell of the list: holds a single element and either keeps it,
// takes its lower neighbour's element, or loads the new value.
// Depends on alis_pkg.
`timescale 1ns / 1ps
`default_nettype none

module alis_cell (
  input  logic                            clk_i,
  input  logic [alis_pkg::IdxW-1:0]       idx_i,
  input  alis_pkg::alis_bcast_t           bc_i,
  input  logic [alis_pkg::DataW-1:0]      prev_i,
  output logic [alis_pkg::DataW-1:0]      data_o
);
  import alis_pkg::*;

  logic [DataW-1:0] data_q, data_d;

  // Land the new value at the insert slot, shift cells above it up by one
  always_comb begin
    data_d = data_q;
    if (bc_i.wr) begin
      if (idx_i == bc_i.pos) begin
        data_d = bc_i.value;
      end else if ((idx_i > bc_i.pos) && (CntW'(idx_i) <= bc_i.len)) begin
        data_d = prev_i;
      end
    end
  end

  // Element storage, no reset needed
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule : alis_cell

`default_nettype wire

// ----- sv/array_list_insert_shift.sv -----
// A result strobes on done_o in the cycle after its operation is taken.
// Throughput: one operation per cycle; busy_o stays low, the row of cells
// shifts every later element in the same cycle as the insert.
// Reset clears the list length and the result strobe; element storage is not
// cleared and needs no clearing pass. The receiver cannot stall results.
`timescale 1ns / 1ps
`default_nettype none

module array_list_insert_shift (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [1:0]                         operation_i,
  input  logic [alis_pkg::PosW-1:0]          position_i,
  input  logic signed [alis_pkg::DataW-1:0]  value_i,
  output logic                               done_o,
  output logic [1:0]                         status_o,
  output logic signed [alis_pkg::DataW-1:0]  read_value_o,
  output logic [alis_pkg::CountOutW-1:0]     count_o
);
  import alis_pkg::*;

  alis_op_e         op;
  alis_status_e     status_d;
  alis_bcast_t      bcast;
  logic [CmpW-1:0]  pos_c, len_c;
  logic             full;
  logic             accept;
  logic [DataW-1:0] rdata_d;

  logic [CntW-1:0]  len_q, len_d;
  logic             done_q;
  alis_status_e     status_q;
  logic [DataW-1:0] rdata_q;

  logic [DataW-1:0] cell_data [CAPACITY];

  assign accept = start_i && !busy_o;
  assign busy_o = 1'b0;
  assign op     = alis_op_e'(operation_i);
  assign pos_c  = CmpW'(position_i);
  assign len_c  = CmpW'(len_q);
  assign full   = (len_q >= CntW'(CAPACITY));

  // Decode the operation: status, length update and the cell write command
  always_comb begin
    status_d    = ST_OK;
    len_d       = len_q;
    rdata_d     = '0;
    bcast.wr    = 1'b0;
    bcast.pos   = len_q[IdxW-1:0];
    bcast.len   = len_q;
    bcast.value = value_i;
    case (op)
      OP_CLEAR: begin
        len_d = '0;
      end
      OP_APPEND: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          bcast.wr = 1'b1;
          len_d    = len_q + CntW'(1);
        end
      end
      OP_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else if (pos_c > len_c) begin
          status_d = ST_RANGE;
        end else begin
          bcast.wr  = 1'b1;
          bcast.pos = pos_c[IdxW-1:0];
          len_d     = len_q + CntW'(1);
        end
      end
      OP_READ: begin
        if (pos_c >= len_c) begin
          status_d = ST_RANGE;
        end else begin
          rdata_d = cell_data[pos_c[IdxW-1:0]];
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
    if (!accept) begin
      bcast.wr = 1'b0;
      len_d    = len_q;
    end
  end

  // Row of storage cells, each fed by its lower neighbour (cell 0 by zero)
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [DataW-1:0] prev;
    if (k == 0) begin : g_first
      assign prev = '0;
    end else begin : g_rest
      assign prev = cell_data[k-1];
    end
    alis_cell u_cell (
      .clk_i  (clk_i),
      .idx_i  (IdxW'(k)),
      .bc_i   (bcast),
      .prev_i (prev),
      .data_o (cell_data[k])
    );
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      done_q <= 1'b0;
    end else begin
      len_q  <= len_d;
      done_q <= accept;
    end
  end

  // Result beat payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      rdata_q  <= rdata_d;
    end
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign read_value_o = rdata_q;
  assign count_o      = CountOutW'(len_q);

`ifndef ASSERT_OFF
  // A result beat only follows a taken operation
  a_done_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(start_i))
    else $error("result beat without a taken operation");

  // Length never exceeds the capacity
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= CntW'(CAPACITY))
    else $error("list length above capacity");

  // A full status means the list really is full
  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (status_q == ST_FULL)) |-> (len_q == CntW'(CAPACITY)))
    else $error("full status with room left");

  // Length holds while no operation is taken
  a_len_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start_i |=> $stable(len_q))
    else $error("length changed without an operation");

  // Failed operations return a zero read value
  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (status_q != ST_OK)) |-> (rdata_q == '0))
    else $error("non-zero read value on error");
`endif

endmodule : array_list_insert_shift

`default_nettype wire

// ----- tb/array_list_insert_shift_tb.sv -----
// Self-checking bench for array_list_insert_shift: a queue of list operations feeds
// a clocked driver, and a clocked monitor checks every result against a shadow list.
// Depends on alis_pkg and the array_list_insert_shift RTL.
`timescale 1ns / 1ps

module array_list_insert_shift_tb;
  import alis_pkg::*;

  localparam int unsigned STALL_LIMIT = 500;
  localparam int unsigned MAX_SHOWN   = 40;
  localparam int unsigned ITEM_TARGET = 1700;

  typedef struct {
    alis_op_e                 op;
    logic [PosW-1:0]          pos;
    logic signed [DataW-1:0]  value;
    int unsigned              gap;
    bit                       drain;
  } list_cmd_t;

  typedef struct {
    logic [1:0]               status;
    logic signed [DataW-1:0]  read_value;
    logic [CountOutW-1:0]     count;
  } list_resp_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       start_i = 1'b0;
  logic [1:0]                 operation_i = OP_CLEAR;
  logic [PosW-1:0]            position_i = '0;
  logic signed [DataW-1:0]    value_i = '0;
  logic                       busy_o;
  logic                       done_o;
  logic [1:0]                 status_o;
  logic signed [DataW-1:0]    read_value_o;
  logic [CountOutW-1:0]       count_o;

  // Stimulus and expectations
  list_cmd_t                  cmd_q[$];
  list_resp_t                 resp_q[$];
  logic                       op_taken = 1'b0;
  int unsigned                idle_cycles = 0;
  int unsigned                error_count = 0;

  // Shadow of the list, advanced on every accepted beat
  logic signed [DataW-1:0]    shadow_mem[CAPACITY];
  int unsigned                shadow_len = 0;

  // Generation-time view of the length, used to aim positions
  int unsigned                plan_len = 0;
  int unsigned                plan_count = 0;
  bit                         quiet_phase = 1'b0;
  bit                         drain_next = 1'b0;

  always #2 clk_i = ~clk_i;

  array_list_insert_shift u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .operation_i  (operation_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .read_value_o (read_value_o),
    .count_o      (count_o)
  );

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_SHOWN) $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // Apply one operation to the shadow list and work out its result
  task automatic apply_list_op(input list_cmd_t cmd, output list_resp_t resp);
    int unsigned k;
    resp.status     = ST_OK;
    resp.read_value = '0;
    case (cmd.op)
      OP_CLEAR: shadow_len = 0;
      OP_APPEND: begin
        if (shadow_len >= CAPACITY) begin
          resp.status = ST_FULL;
        end else begin
          shadow_mem[shadow_len] = cmd.value;
          shadow_len++;
        end
      end
      OP_INSERT: begin
        if (shadow_len >= CAPACITY) begin
          resp.status = ST_FULL;
        end else if (cmd.pos > shadow_len) begin
          resp.status = ST_RANGE;
        end else begin
          for (k = shadow_len; k > cmd.pos; k--) shadow_mem[k] = shadow_mem[k-1];
          shadow_mem[cmd.pos] = cmd.value;
          shadow_len++;
        end
      end
      default: begin
        if (cmd.pos >= shadow_len) resp.status = ST_RANGE;
        else resp.read_value = shadow_mem[cmd.pos];
      end
    endcase
    resp.count = CountOutW'(shadow_len);
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Extremes turn up often enough to matter
  function automatic logic [DataW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Queue one operation and track the length it leaves behind
  task automatic queue_cmd(input alis_op_e op, input int unsigned pos,
                           input logic [DataW-1:0] val);
    list_cmd_t c;
    c.op    = op;
    c.pos   = PosW'(pos);
    c.value = val;
    c.gap   = pick_gap();
    c.drain = drain_next;
    drain_next = 1'b0;
    cmd_q.push_back(c);
    plan_count++;
    case (op)
      OP_CLEAR:  plan_len = 0;
      OP_APPEND: if (plan_len < CAPACITY) plan_len++;
      OP_INSERT: if (plan_len < CAPACITY && c.pos <= plan_len) plan_len++;
      default: ;
    endcase
  endtask

  function automatic int unsigned aim_insert_pos();
    int unsigned top;
    top = (plan_len > CAPACITY - 1) ? CAPACITY - 1 : plan_len;
    if ($urandom_range(0, 99) < 85) return $urandom_range(0, top);
    return $urandom_range(0, (1 << PosW) - 1);
  endfunction

  function automatic int unsigned aim_read_pos();
    if (plan_len != 0 && $urandom_range(0, 99) < 80) return $urandom_range(0, plan_len - 1);
    return $urandom_range(0, (1 << PosW) - 1);
  endfunction

  // Driver: presents the next beat at the falling edge, holds it until taken
  always @(negedge clk_i) begin : drv
    int unsigned gap_left;
    list_cmd_t   nxt;
    if (rst_ni && !(start_i && !op_taken)) begin
      if (gap_left != 0) begin
        gap_left--;
        start_i <= 1'b0;
      end else if (cmd_q.size() == 0) begin
        start_i <= 1'b0;
      end else if (cmd_q[0].drain && resp_q.size() != 0) begin
        start_i <= 1'b0;
      end else if (cmd_q[0].gap != 0) begin
        gap_left = cmd_q[0].gap - 1;
        cmd_q[0].gap = 0;
        start_i <= 1'b0;
      end else begin
        nxt = cmd_q.pop_front();
        start_i     <= 1'b1;
        operation_i <= nxt.op;
        position_i  <= nxt.pos;
        value_i     <= nxt.value;
      end
    end
  end

  // Monitor: checks result beats and predicts for accepted command beats
  always @(posedge clk_i) begin : mon
    list_cmd_t  cmd;
    list_resp_t want;
    list_resp_t got;
    bit         moved;
    op_taken <= rst_ni && start_i && !busy_o;
    if (rst_ni) begin
      moved = 1'b0;
      if (done_o) begin
        moved = 1'b1;
        if (resp_q.size() == 0) begin
          report_mismatch("result beat with no operation outstanding");
        end else begin
          want = resp_q.pop_front();
          if (status_o !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", status_o, want.status));
          if (read_value_o !== want.read_value)
            report_mismatch($sformatf("read_value %0d, expected %0d",
                                      read_value_o, want.read_value));
          if (count_o !== want.count)
            report_mismatch($sformatf("count %0d, expected %0d", count_o, want.count));
        end
      end
      if (start_i && !busy_o) begin
        moved     = 1'b1;
        cmd.op    = alis_op_e'(operation_i);
        cmd.pos   = position_i;
        cmd.value = value_i;
        cmd.gap   = 0;
        cmd.drain = 1'b0;
        apply_list_op(cmd, got);
        resp_q.push_back(got);
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
    end
  end

  // Watchdog: no beat on either side for too long
  initial begin : watchdog
    @(posedge rst_ni);
    while (idle_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stim
    int unsigned kind;
    int unsigned n;
    int unsigned r;
    bit          first_fill;
    first_fill = 1'b1;

    // Directed: empty list, extremes, front/middle/end inserts, range errors, clear
    quiet_phase = 1'b1;
    queue_cmd(OP_READ, 0, 32'h0);
    queue_cmd(OP_INSERT, 3, 32'h1234_5678);
    queue_cmd(OP_APPEND, 0, 32'h7FFF_FFFF);
    queue_cmd(OP_APPEND, 127, 32'h8000_0000);
    queue_cmd(OP_INSERT, 0, 32'h0000_0000);
    queue_cmd(OP_INSERT, 3, 32'hFFFF_FFFF);
    queue_cmd(OP_INSERT, 2, 32'h0000_3039);
    for (int i = 0; i < 5; i++) queue_cmd(OP_READ, i, 32'hFFFF_FFFF);
    queue_cmd(OP_READ, 5, 32'h0);
    queue_cmd(OP_READ, 127, 32'h0);
    queue_cmd(OP_INSERT, 127, 32'h5555_AAAA);
    queue_cmd(OP_INSERT, 6, 32'hAAAA_5555);
    queue_cmd(OP_CLEAR, 127, 32'hFFFF_FFFF);
    queue_cmd(OP_READ, 0, 32'h0);
    queue_cmd(OP_CLEAR, 0, 32'h0);
    queue_cmd(OP_APPEND, 0, $urandom());
    queue_cmd(OP_READ, 0, 32'h0);

    // Random episodes: fills to capacity, aimed bursts and raw noise
    while (plan_count < ITEM_TARGET) begin
      kind = first_fill ? 0 : $urandom_range(0, 9);
      quiet_phase = ($urandom_range(0, 4) == 0);
      if (first_fill || $urandom_range(0, 9) < 3) drain_next = 1'b1;
      first_fill = 1'b0;
      if (kind < 3) begin
        if ($urandom_range(0, 1)) queue_cmd(OP_CLEAR, $urandom_range(0, 127), pick_value());
        while (plan_len < CAPACITY) begin
          r = $urandom_range(0, 9);
          if (r < 4) queue_cmd(OP_APPEND, $urandom_range(0, 127), pick_value());
          else if (r < 8) queue_cmd(OP_INSERT, $urandom_range(0, plan_len), pick_value());
          else queue_cmd(OP_READ, aim_read_pos(), pick_value());
        end
        n = $urandom_range(2, 5);
        repeat (n) begin
          if ($urandom_range(0, 1)) queue_cmd(OP_APPEND, $urandom_range(0, 127), pick_value());
          else queue_cmd(OP_INSERT, $urandom_range(0, 127), pick_value());
        end
        queue_cmd(OP_READ, 127, pick_value());
        n = $urandom_range(4, 10);
        repeat (n) queue_cmd(OP_READ, $urandom_range(0, 127), pick_value());
      end else if (kind < 9) begin
        n = $urandom_range(20, 80);
        repeat (n) begin
          r = $urandom_range(0, 99);
          if (r < 3) queue_cmd(OP_CLEAR, $urandom_range(0, 127), pick_value());
          else if (r < 28) queue_cmd(OP_APPEND, $urandom_range(0, 127), pick_value());
          else if (r < 65) queue_cmd(OP_INSERT, aim_insert_pos(), pick_value());
          else queue_cmd(OP_READ, aim_read_pos(), pick_value());
        end
      end else begin
        n = $urandom_range(10, 30);
        repeat (n) queue_cmd(alis_op_e'($urandom_range(0, 3)), $urandom_range(0, 127), $urandom());
      end
    end

    // Reset once, released away from the rising edge
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (cmd_q.size() != 0 || start_i) @(posedge clk_i);
    while (resp_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    if (error_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/alis_pkg.sv
sv/alis_cell.sv
sv/array_list_insert_shift.sv
tb/array_list_insert_shift_tb.sv
